// File: sv/mhtq_pkg.sv
// shared types and constants of the timer heap queue
package mhtq_pkg;

  localparam int ENTRIES  = 512;
  localparam int MAX_FIRE = 63;
  localparam int QDEPTH   = 2;

  localparam int IW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int LW  = IW + 2;
  localparam int FW  = $clog2(MAX_FIRE + 1);
  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_EXP  = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] start_ms;
    logic [31:0] period_ms;
    logic        repeat_req;
    logic [31:0] message_id;
    logic [7:0]  dest_module;
    logic [31:0] target_id;
    logic [15:0] elapsed_ms;
  } cmd_req_t;

  typedef struct packed {
    logic [47:0] expiry;
    logic [31:0] interval;
    logic        rep;
    logic [31:0] message;
    logic [7:0]  dest;
    logic [31:0] id;
  } entry_t;

endpackage

// File: sv/mhtq_if.sv
// channel interfaces for commands and results
interface mhtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] start_ms;
  logic [31:0] period_ms;
  logic        repeat_req;
  logic [31:0] message_id;
  logic [7:0]  dest_module;
  logic [31:0] target_id;
  logic [15:0] elapsed_ms;

  modport source (output valid, cmd, start_ms, period_ms, repeat_req, message_id,
                  dest_module, target_id, elapsed_ms, input ready);
  modport sink (input valid, cmd, start_ms, period_ms, repeat_req, message_id,
                dest_module, target_id, elapsed_ms, output ready);
endinterface

interface mhtq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [31:0] tmr_tag;
  logic [31:0] fired_message;
  logic [7:0]  fired_dest;
  logic        has_pending;
  logic [47:0] next_delay_ms;
  logic        last;

  modport source (output valid, kind, status, tmr_tag, fired_message, fired_dest,
                  has_pending, next_delay_ms, last, input ready);
  modport sink (input valid, kind, status, tmr_tag, fired_message, fired_dest,
                has_pending, next_delay_ms, last, output ready);
endinterface

// File: sv/mhtq_front.sv
// command intake: drops unknown codes and queues the rest for the heap engine
module mhtq_front
  import mhtq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  mhtq_in_if.sink      in_ch,
  output logic         q_valid,
  output cmd_req_t     q_data,
  input  logic         q_ready
);

  cmd_req_t         q_mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0]   qcnt_r, qcnt_nxt;
  cmd_req_t         req_w;
  logic             push_w, pop_w;

  always_comb begin
    req_w.cmd         = cmd_t'(in_ch.cmd);
    req_w.start_ms    = in_ch.start_ms;
    req_w.period_ms   = in_ch.period_ms;
    req_w.repeat_req  = in_ch.repeat_req;
    req_w.message_id  = in_ch.message_id;
    req_w.dest_module = in_ch.dest_module;
    req_w.target_id   = in_ch.target_id;
    req_w.elapsed_ms  = in_ch.elapsed_ms;
  end

  assign in_ch.ready = (qcnt_r != QCW'(QDEPTH));
  // unknown code is taken and thrown away
  assign push_w  = in_ch.valid && in_ch.ready && (req_w.cmd != CMD_NONE);
  assign q_valid = (qcnt_r != '0);
  assign q_data  = q_mem_r[rp_r];
  assign pop_w   = q_valid && q_ready;

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    qcnt_nxt = qcnt_r;
    if (push_w) begin
      wp_nxt = (wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + QAW'(1);
    end
    if (pop_w) begin
      rp_nxt = (rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + QAW'(1);
    end
    if (push_w && !pop_w) begin
      qcnt_nxt = qcnt_r + QCW'(1);
    end else if (!push_w && pop_w) begin
      qcnt_nxt = qcnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      qcnt_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      qcnt_r <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_w) begin
      q_mem_r[wp_r] <= req_w;
    end
  end

endmodule

// File: sv/mhtq_core.sv
// heap engine: sequencer over the slot memory, clock, ids and result register
module mhtq_core
  import mhtq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  cmd_req_t     q_data,
  output logic         q_ready,
  mhtq_out_if.source   out_ch
);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_ADD    = 18'h00002,
    S_SRD    = 18'h00004,
    S_SCHK   = 18'h00008,
    S_DLAST  = 18'h00010,
    S_UPRD   = 18'h00020,
    S_UPCMP  = 18'h00040,
    S_DNL    = 18'h00080,
    S_DNR    = 18'h00100,
    S_DNCMP  = 18'h00200,
    S_TSTART = 18'h00400,
    S_TCHK   = 18'h00800,
    S_TCHK2  = 18'h01000,
    S_TLAST  = 18'h02000,
    S_TEMIT  = 18'h04000,
    S_TREP   = 18'h08000,
    S_FINRD  = 18'h10000,
    S_FIN    = 18'h20000
  } state_t;

  typedef enum logic [1:0] {
    CTX_ADD = 2'd0,
    CTX_DEL = 2'd1,
    CTX_POP = 2'd2,
    CTX_REP = 2'd3
  } ctx_t;

  state_t          state_r, state_nxt, ret_w;
  ctx_t            ctx_r, ctx_nxt;
  cmd_req_t        cmd_r, cmd_nxt;
  logic [IW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, sk_r, sk_nxt;
  logic [47:0]     now_r, now_nxt;
  logic [31:0]     nid_r, nid_nxt;
  logic [FW-1:0]   pops_r, pops_nxt;
  entry_t          cur_r, cur_nxt, lch_r, lch_nxt, pop_r, pop_nxt;
  logic            rok_r, rok_nxt, moved_r, moved_nxt;
  kind_t           fkind_r, fkind_nxt;
  status_t         fstat_r, fstat_nxt;
  logic [31:0]     fid_r, fid_nxt;

  entry_t          heap_mem [ENTRIES];
  entry_t          rdata_r;
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata;

  logic            ov_r, ov_nxt, out_free;
  kind_t           okind_r, okind_nxt;
  status_t         ostat_r, ostat_nxt;
  logic [31:0]     oid_r, oid_nxt, omsg_r, omsg_nxt;
  logic [7:0]      odst_r, odst_nxt;
  logic            opend_r, opend_nxt, olast_r, olast_nxt;
  logic [47:0]     odly_r, odly_nxt;

  logic [IW-1:0]   parent_w, last_idx_w;
  logic [LW-1:0]   l_w, r_w, cnt_ext_w;
  logic [CW-1:0]   cnt_m1_w;
  logic [31:0]     ivl_eff_w;
  logic            full_w;
  entry_t          best_w;
  logic            best_l_w, best_r_w;

  assign out_free   = !ov_r || out_ch.ready;
  assign parent_w   = (k_r - IW'(1)) >> 1;
  assign l_w        = {1'b0, k_r, 1'b1};
  assign r_w        = l_w + LW'(1);
  assign cnt_ext_w  = LW'(cnt_r);
  assign cnt_m1_w   = cnt_r - CW'(1);
  assign last_idx_w = cnt_m1_w[IW-1:0];
  assign full_w     = (cnt_r == CW'(ENTRIES));
  assign ivl_eff_w  = (pop_r.interval == 32'd0) ? 32'd1 : pop_r.interval;
  assign q_ready    = (state_r == S_IDLE);

  always_comb begin
    unique case (ctx_r)
      CTX_ADD, CTX_DEL: ret_w = S_FINRD;
      CTX_POP:          ret_w = S_TEMIT;
      CTX_REP:          ret_w = S_TCHK;
      default:          ret_w = S_FINRD;
    endcase
  end

  // smaller child, left first on equal keys
  always_comb begin
    best_w   = cur_r;
    best_l_w = 1'b0;
    best_r_w = 1'b0;
    if (lch_r.expiry < cur_r.expiry) begin
      best_w   = lch_r;
      best_l_w = 1'b1;
    end
    if (rok_r && (rdata_r.expiry < best_w.expiry)) begin
      best_w   = rdata_r;
      best_l_w = 1'b0;
      best_r_w = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctx_nxt   = ctx_r;
    cmd_nxt   = cmd_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    sk_nxt    = sk_r;
    now_nxt   = now_r;
    nid_nxt   = nid_r;
    pops_nxt  = pops_r;
    cur_nxt   = cur_r;
    lch_nxt   = lch_r;
    pop_nxt   = pop_r;
    rok_nxt   = rok_r;
    moved_nxt = moved_r;
    fkind_nxt = fkind_r;
    fstat_nxt = fstat_r;
    fid_nxt   = fid_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = k_r;
    mem_raddr = '0;
    mem_wdata = cur_r;
    ov_nxt    = out_ch.ready ? 1'b0 : ov_r;
    okind_nxt = okind_r;
    ostat_nxt = ostat_r;
    oid_nxt   = oid_r;
    omsg_nxt  = omsg_r;
    odst_nxt  = odst_r;
    opend_nxt = opend_r;
    olast_nxt = olast_r;
    odly_nxt  = odly_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cmd_nxt = q_data;
          unique case (q_data.cmd)
            CMD_ADD:  state_nxt = S_ADD;
            CMD_DEL: begin
              sk_nxt    = '0;
              state_nxt = S_SRD;
            end
            CMD_TICK: state_nxt = S_TSTART;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        nid_nxt   = nid_r + 32'd1;
        fkind_nxt = KIND_ADD;
        if (full_w) begin
          fstat_nxt = ST_FULL;
          fid_nxt   = 32'hFFFF_FFFF;
          state_nxt = S_FINRD;
        end else begin
          fstat_nxt        = ST_OK;
          fid_nxt          = nid_r;
          cur_nxt.expiry   = now_r + {16'd0, cmd_r.start_ms};
          cur_nxt.interval = cmd_r.period_ms;
          cur_nxt.rep      = cmd_r.repeat_req;
          cur_nxt.message  = cmd_r.message_id;
          cur_nxt.dest     = cmd_r.dest_module;
          cur_nxt.id       = nid_r;
          k_nxt            = cnt_r[IW-1:0];
          cnt_nxt          = cnt_r + CW'(1);
          ctx_nxt          = CTX_ADD;
          moved_nxt        = 1'b0;
          state_nxt        = S_UPRD;
        end
      end
      // linear id search, each slot read in S_SRD and checked in S_SCHK
      S_SRD: begin
        fkind_nxt = KIND_DEL;
        fid_nxt   = cmd_r.target_id;
        if (sk_r == cnt_r) begin
          fstat_nxt = ST_NOTFOUND;
          state_nxt = S_FINRD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = sk_r[IW-1:0];
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (rdata_r.id == cmd_r.target_id) begin
          fstat_nxt = ST_OK;
          cnt_nxt   = cnt_m1_w;
          k_nxt     = sk_r[IW-1:0];
          if (sk_r < cnt_m1_w) begin
            mem_re    = 1'b1;
            mem_raddr = last_idx_w;
            state_nxt = S_DLAST;
          end else begin
            state_nxt = S_FINRD;
          end
        end else begin
          sk_nxt    = sk_r + CW'(1);
          state_nxt = S_SRD;
        end
      end
      S_DLAST: begin
        cur_nxt   = rdata_r;
        moved_nxt = 1'b0;
        ctx_nxt   = CTX_DEL;
        state_nxt = S_UPRD;
      end
      S_UPRD: begin
        if (k_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = (ctx_r == CTX_DEL && !moved_r) ? S_DNL : ret_w;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent_w;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        mem_we = 1'b1;
        if (cur_r.expiry < rdata_r.expiry) begin
          mem_wdata = rdata_r;
          k_nxt     = parent_w;
          moved_nxt = 1'b1;
          state_nxt = S_UPRD;
        end else begin
          // an entry that did not rise may still have to sink
          state_nxt = (ctx_r == CTX_DEL && !moved_r) ? S_DNL : ret_w;
        end
      end
      S_DNL: begin
        if (l_w >= cnt_ext_w) begin
          mem_we    = 1'b1;
          state_nxt = ret_w;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = l_w[IW-1:0];
          state_nxt = S_DNR;
        end
      end
      S_DNR: begin
        lch_nxt = rdata_r;
        rok_nxt = (r_w < cnt_ext_w);
        if (r_w < cnt_ext_w) begin
          mem_re    = 1'b1;
          mem_raddr = r_w[IW-1:0];
        end
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        mem_we = 1'b1;
        if (best_l_w || best_r_w) begin
          mem_wdata = best_w;
          k_nxt     = best_l_w ? l_w[IW-1:0] : r_w[IW-1:0];
          state_nxt = S_DNL;
        end else begin
          state_nxt = ret_w;
        end
      end
      S_TSTART: begin
        now_nxt   = now_r + {32'd0, cmd_r.elapsed_ms};
        pops_nxt  = '0;
        fkind_nxt = KIND_TICK;
        fstat_nxt = ST_OK;
        fid_nxt   = 32'd0;
        state_nxt = S_TCHK;
      end
      S_TCHK: begin
        if (pops_r == FW'(MAX_FIRE) || cnt_r == '0) begin
          state_nxt = S_FINRD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = S_TCHK2;
        end
      end
      S_TCHK2: begin
        if (rdata_r.expiry <= now_r) begin
          pop_nxt  = rdata_r;
          pops_nxt = pops_r + FW'(1);
          cnt_nxt  = cnt_m1_w;
          if (cnt_m1_w != '0) begin
            mem_re    = 1'b1;
            mem_raddr = last_idx_w;
            state_nxt = S_TLAST;
          end else begin
            state_nxt = S_TEMIT;
          end
        end else begin
          state_nxt = S_FINRD;
        end
      end
      S_TLAST: begin
        cur_nxt   = rdata_r;
        k_nxt     = '0;
        ctx_nxt   = CTX_POP;
        state_nxt = S_DNL;
      end
      S_TEMIT: begin
        if (pop_r.message == 32'd0) begin
          state_nxt = S_TREP;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_EXP;
          ostat_nxt = ST_OK;
          oid_nxt   = pop_r.id;
          omsg_nxt  = pop_r.message;
          odst_nxt  = pop_r.dest;
          opend_nxt = 1'b0;
          odly_nxt  = 48'd0;
          olast_nxt = 1'b0;
          state_nxt = S_TREP;
        end
      end
      S_TREP: begin
        if (pop_r.rep && !full_w) begin
          cur_nxt        = pop_r;
          cur_nxt.expiry = pop_r.expiry + {16'd0, ivl_eff_w};
          k_nxt          = cnt_r[IW-1:0];
          cnt_nxt        = cnt_r + CW'(1);
          ctx_nxt        = CTX_REP;
          moved_nxt      = 1'b0;
          state_nxt      = S_UPRD;
        end else begin
          state_nxt = S_TCHK;
        end
      end
      S_FINRD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = fkind_r;
          ostat_nxt = fstat_r;
          oid_nxt   = fid_r;
          omsg_nxt  = 32'd0;
          odst_nxt  = 8'd0;
          olast_nxt = 1'b1;
          opend_nxt = (cnt_r != '0);
          if (cnt_r == '0) begin
            odly_nxt = 48'd0;
          end else if (rdata_r.expiry > now_r) begin
            odly_nxt = rdata_r.expiry - now_r;
          end else begin
            odly_nxt = 48'd1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      now_r   <= '0;
      nid_r   <= '0;
      pops_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      now_r   <= now_nxt;
      nid_r   <= nid_nxt;
      pops_r  <= pops_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r   <= ctx_nxt;
    cmd_r   <= cmd_nxt;
    k_r     <= k_nxt;
    sk_r    <= sk_nxt;
    cur_r   <= cur_nxt;
    lch_r   <= lch_nxt;
    pop_r   <= pop_nxt;
    rok_r   <= rok_nxt;
    moved_r <= moved_nxt;
    fkind_r <= fkind_nxt;
    fstat_r <= fstat_nxt;
    fid_r   <= fid_nxt;
    okind_r <= okind_nxt;
    ostat_r <= ostat_nxt;
    oid_r   <= oid_nxt;
    omsg_r  <= omsg_nxt;
    odst_r  <= odst_nxt;
    opend_r <= opend_nxt;
    olast_r <= olast_nxt;
    odly_r  <= odly_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= heap_mem[mem_raddr];
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.kind          = okind_r;
  assign out_ch.status        = ostat_r;
  assign out_ch.tmr_tag       = oid_r;
  assign out_ch.fired_message = omsg_r;
  assign out_ch.fired_dest    = odst_r;
  assign out_ch.has_pending   = opend_r;
  assign out_ch.next_delay_ms = odly_r;
  assign out_ch.last          = olast_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ENTRIES))
    else $error("heap count beyond capacity");

  a_pops_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pops_r <= FW'(MAX_FIRE))
    else $error("fire count beyond limit");

  a_sift_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPRD || state_r == S_DNL) |-> (CW'(k_r) < cnt_r))
    else $error("sift position outside the heap");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && state_nxt == S_IDLE) |=> (ov_r && olast_r))
    else $error("final result not loaded");

endmodule

// File: sv/min_heap_timer_queue.sv
// top level of the timer heap queue
//   channel | dir | handshake         | word
//   in_ch   | in  | valid/ready       | command: add, delete or tick
//   out_ch  | out | valid/ready       | result: ack, expiry or tick done
// add: climbs the heap level by level; delete: searches the slots one by one, then
// sifts the moved entry; tick: pops due timers, sifting down after each one,
// up to 63 pops. all heap steps share one slot memory port.
// synchronous active-low reset clears count, clock and ids; slot memory is not cleared.
// a stalled result holds the engine; the two-deep command queue keeps taking input until full.
module min_heap_timer_queue
  import mhtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mhtq_in_if.sink     in_ch,
  mhtq_out_if.source  out_ch
);

  logic      q_valid, q_ready;
  cmd_req_t  q_data;

  mhtq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready)
  );

  mhtq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule
